/* sv/pssh_pkg.sv */
//------------------------------------------------------------------------------
// Protection-system box parser package
// Widths, field codes and the result record shared by the parser, its
// channel interfaces and its checker.
//------------------------------------------------------------------------------
`default_nettype none

package pssh_pkg;

	localparam int KEY_ID_BYTES    = 16;
	localparam int SYSTEM_ID_BYTES = 16;
	localparam int KEY_SHIFT       = $clog2(KEY_ID_BYTES);
	localparam int SYSID_BITS      = 8 * SYSTEM_ID_BYTES;

	localparam int WORD_W     = 32;
	localparam int KEY_IDX_W  = 28;
	localparam int KEY_POS_W  = $clog2(KEY_ID_BYTES);
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 64;

	// Register indexes on the configuration channel.
	localparam logic [CFG_IDX_W-1:0] REG_SYSID_HIGH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SYSID_LOW  = 1'b1;

	// Kind of byte carried by a result.
	localparam logic [1:0] KIND_NONE    = 2'd0;
	localparam logic [1:0] KIND_KEY     = 2'd1;
	localparam logic [1:0] KIND_PAYLOAD = 2'd2;

	// Box status, valid on the result of the last byte.
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_SKIPPED  = 2'd1;
	localparam logic [1:0] STATUS_MISMATCH = 2'd2;
	localparam logic [1:0] STATUS_INVALID  = 2'd3;

	typedef struct packed {
		logic [1:0]           byte_kind;
		logic [7:0]           out_byte;
		logic [KEY_IDX_W-1:0] key_index;
		logic [KEY_POS_W-1:0] key_byte_pos;
		logic [WORD_W-1:0]    payload_offset;
		logic                 done_res;
		logic [1:0]           status;
	} result_t;

endpackage

`default_nettype wire

/* sv/pssh_if.sv */
//------------------------------------------------------------------------------
// Protection-system box parser channels
// Valid/ready interfaces for box bytes, results and register writes.
//------------------------------------------------------------------------------
`default_nettype none

interface pssh_in_if
	import pssh_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [7:0]        data_byte;
	logic [WORD_W-1:0] buffer_size;
	logic              last_byte;

	modport source (output valid, data_byte, buffer_size, last_byte, input ready);
	modport sink   (input valid, data_byte, buffer_size, last_byte, output ready);
endinterface

interface pssh_out_if
	import pssh_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [1:0]           byte_kind;
	logic [7:0]           out_byte;
	logic [KEY_IDX_W-1:0] key_index;
	logic [KEY_POS_W-1:0] key_byte_pos;
	logic [WORD_W-1:0]    payload_offset;
	logic                 done_res;
	logic [1:0]           status;

	modport source (output valid, byte_kind, out_byte, key_index, key_byte_pos,
		payload_offset, done_res, status, input ready);
	modport sink   (input valid, byte_kind, out_byte, key_index, key_byte_pos,
		payload_offset, done_res, status, output ready);
endinterface

interface pssh_cfg_if
	import pssh_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/pssh_box_parser.sv */
//------------------------------------------------------------------------------
// Protection-system box parser
// Walks one protection-system box a byte at a time, checks its length and
// system id, and emits the key-id and payload bytes with a final status.
//------------------------------------------------------------------------------
//
//  Channel  Role    Transfer carries
//  -------  ------  -----------------------------------------------------------
//  box      sink    data_byte, buffer_size, last_byte: one box byte
//  result   source  byte_kind, out_byte, key_index, key_byte_pos,
//                   payload_offset, done_res, status: one result per byte
//  cfg      sink    index, data: write of a system-id half
//
// Every box byte gives exactly one result, in the cycle after its transfer;
// a new byte can be taken in every cycle while results are taken, since the
// parse state and the result register both update in the cycle of the transfer.
// The result register frees itself whenever the result is taken, so a byte is
// taken in the same cycle as the previous result leaves; box.ready only drops
// while a result is held up by result.ready.
// Reset puts the parser at the start of a box with the system id all zeros.
// The cfg channel is always ready.
//
`default_nettype none

module pssh_box_parser
	import pssh_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	pssh_in_if.sink     box,
	pssh_out_if.source  result,
	pssh_cfg_if.sink    cfg
);

	// Parse phases.
	localparam logic [3:0] PH_LEN     = 4'd0;
	localparam logic [3:0] PH_TYPE    = 4'd1;
	localparam logic [3:0] PH_VER     = 4'd2;
	localparam logic [3:0] PH_FLAGS   = 4'd3;
	localparam logic [3:0] PH_SYSID   = 4'd4;
	localparam logic [3:0] PH_KCOUNT  = 4'd5;
	localparam logic [3:0] PH_KEYS    = 4'd6;
	localparam logic [3:0] PH_DSIZE   = 4'd7;
	localparam logic [3:0] PH_PAYLOAD = 4'd8;
	localparam logic [3:0] PH_DONE    = 4'd9;
	localparam logic [3:0] PH_DRAIN   = 4'd10;

	localparam int FC_W = $clog2(SYSTEM_ID_BYTES);

	localparam logic [FC_W-1:0]      WORD_LAST_FC  = FC_W'(3);
	localparam logic [FC_W-1:0]      FLAGS_LAST_FC = FC_W'(2);
	localparam logic [FC_W-1:0]      SYSID_LAST_FC = FC_W'(SYSTEM_ID_BYTES - 1);
	localparam logic [KEY_POS_W-1:0] KEY_LAST_POS  = KEY_POS_W'(KEY_ID_BYTES - 1);

	// Configured system id, big endian: byte 0 sits in the top bits.
	logic [CFG_DATA_W-1:0] sysid_high_q;
	logic [CFG_DATA_W-1:0] sysid_low_q;

	// Parse state.
	logic [3:0]           phase_q;
	logic [WORD_W-1:0]    byte_pos_q;
	logic [WORD_W-1:0]    decl_len_q;
	logic                 ver_nz_q;
	logic                 id_match_q;
	logic [WORD_W-1:0]    field_q;
	logic [FC_W-1:0]      fcount_q;
	logic [WORD_W-1:0]    keys_left_q;
	logic [KEY_IDX_W-1:0] key_seen_q;
	logic [KEY_POS_W-1:0] key_pos_q;
	logic [WORD_W-1:0]    pay_left_q;
	logic [WORD_W-1:0]    pay_pos_q;
	logic [1:0]           outcome_q;

	// Result register.
	logic    res_valid_q;
	result_t res_q;

	// Next-state values.
	logic [3:0]           phase_d;
	logic [WORD_W-1:0]    byte_pos_d;
	logic [WORD_W-1:0]    decl_len_d;
	logic                 ver_nz_d;
	logic                 id_match_d;
	logic [WORD_W-1:0]    field_d;
	logic [FC_W-1:0]      fcount_d;
	logic [WORD_W-1:0]    keys_left_d;
	logic [KEY_IDX_W-1:0] key_seen_d;
	logic [KEY_POS_W-1:0] key_pos_d;
	logic [WORD_W-1:0]    pay_left_d;
	logic [WORD_W-1:0]    pay_pos_d;
	logic [1:0]           outcome_d;
	result_t              res_d;

	logic                    take;
	logic [WORD_W-1:0]       field_shift;
	logic                    word_done;
	logic [WORD_W-1:0]       remaining;
	logic [WORD_W+KEY_SHIFT-1:0] key_need;
	logic [SYSID_BITS-1:0]   sysid;
	logic [7:0]              id_byte;
	logic [WORD_W-1:0]       keys_left_dec;
	logic [WORD_W-1:0]       pay_left_dec;

	// A byte is taken whenever the result register is empty or being emptied.
	assign box.ready = !res_valid_q || result.ready;
	assign take      = box.valid && box.ready;
	assign cfg.ready = 1'b1;

	always_comb begin
		// Big-endian 32-bit fields are collected a byte at a time.
		field_shift = {field_q[WORD_W-9:0], box.data_byte};
		word_done   = (fcount_q == WORD_LAST_FC);
		byte_pos_d  = byte_pos_q + WORD_W'(1);
		// Bytes of the declared length still to come after this one.
		remaining   = (decl_len_q > byte_pos_d) ? (decl_len_q - byte_pos_d) : '0;
		key_need    = {{KEY_SHIFT{1'b0}}, field_shift} << KEY_SHIFT;
		sysid       = {sysid_high_q, sysid_low_q};
		id_byte     = sysid[SYSID_BITS - 1 - 8 * fcount_q -: 8];
		keys_left_dec = keys_left_q - WORD_W'(1);
		pay_left_dec  = pay_left_q - WORD_W'(1);

		phase_d     = phase_q;
		decl_len_d  = decl_len_q;
		ver_nz_d    = ver_nz_q;
		id_match_d  = id_match_q;
		field_d     = field_q;
		fcount_d    = fcount_q;
		keys_left_d = keys_left_q;
		key_seen_d  = key_seen_q;
		key_pos_d   = key_pos_q;
		pay_left_d  = pay_left_q;
		pay_pos_d   = pay_pos_q;
		outcome_d   = outcome_q;
		res_d       = '0;

		unique case (phase_q)
			PH_LEN: begin
				field_d  = field_shift;
				fcount_d = fcount_q + FC_W'(1);
				if (word_done) begin
					decl_len_d = field_shift;
					field_d    = '0;
					fcount_d   = '0;
					if (field_shift != box.buffer_size) begin
						outcome_d = STATUS_MISMATCH;
						phase_d   = PH_DRAIN;
					end else begin
						phase_d = PH_TYPE;
					end
				end
			end
			PH_TYPE: begin
				fcount_d = fcount_q + FC_W'(1);
				if (word_done) begin
					fcount_d = '0;
					phase_d  = PH_VER;
				end
			end
			PH_VER: begin
				ver_nz_d = (box.data_byte != 8'd0);
				phase_d  = PH_FLAGS;
			end
			PH_FLAGS: begin
				fcount_d = fcount_q + FC_W'(1);
				if (fcount_q == FLAGS_LAST_FC) begin
					fcount_d = '0;
					phase_d  = PH_SYSID;
				end
			end
			PH_SYSID: begin
				if (box.data_byte != id_byte) begin
					id_match_d = 1'b0;
				end
				fcount_d = fcount_q + FC_W'(1);
				if (fcount_q == SYSID_LAST_FC) begin
					fcount_d = '0;
					field_d  = '0;
					if (!id_match_d) begin
						outcome_d = STATUS_SKIPPED;
						phase_d   = PH_DRAIN;
					end else begin
						phase_d = ver_nz_q ? PH_KCOUNT : PH_DSIZE;
					end
				end
			end
			PH_KCOUNT: begin
				field_d  = field_shift;
				fcount_d = fcount_q + FC_W'(1);
				if (word_done) begin
					fcount_d = '0;
					field_d  = '0;
					// The key ids must fit in what is left of the box.
					if (key_need > {{KEY_SHIFT{1'b0}}, remaining}) begin
						outcome_d = STATUS_INVALID;
						phase_d   = PH_DRAIN;
					end else begin
						keys_left_d = field_shift;
						key_seen_d  = '0;
						key_pos_d   = '0;
						phase_d     = (field_shift != '0) ? PH_KEYS : PH_DSIZE;
					end
				end
			end
			PH_KEYS: begin
				res_d.byte_kind    = KIND_KEY;
				res_d.out_byte     = box.data_byte;
				res_d.key_index    = key_seen_q;
				res_d.key_byte_pos = key_pos_q;
				if (key_pos_q == KEY_LAST_POS) begin
					key_pos_d   = '0;
					key_seen_d  = key_seen_q + KEY_IDX_W'(1);
					keys_left_d = keys_left_dec;
					if (keys_left_dec == '0) begin
						phase_d = PH_DSIZE;
					end
				end else begin
					key_pos_d = key_pos_q + KEY_POS_W'(1);
				end
			end
			PH_DSIZE: begin
				field_d  = field_shift;
				fcount_d = fcount_q + FC_W'(1);
				if (word_done) begin
					fcount_d   = '0;
					field_d    = '0;
					pay_left_d = field_shift;
					pay_pos_d  = '0;
					if (field_shift > remaining) begin
						outcome_d = STATUS_INVALID;
						phase_d   = PH_DRAIN;
					end else begin
						phase_d = (field_shift != '0) ? PH_PAYLOAD : PH_DONE;
					end
				end
			end
			PH_PAYLOAD: begin
				res_d.byte_kind      = KIND_PAYLOAD;
				res_d.out_byte       = box.data_byte;
				res_d.payload_offset = pay_pos_q;
				pay_pos_d            = pay_pos_q + WORD_W'(1);
				pay_left_d           = pay_left_dec;
				if (pay_left_dec == '0) begin
					phase_d = PH_DONE;
				end
			end
			default: begin
				// Done or draining: trailing bytes change nothing.
			end
		endcase

		// The last byte reports the status and rearms the parser.
		if (box.last_byte) begin
			res_d.done_res = 1'b1;
			if (outcome_d != STATUS_OK) begin
				res_d.status = outcome_d;
			end else begin
				res_d.status = (phase_d == PH_DONE) ? STATUS_OK : STATUS_INVALID;
			end
			phase_d     = PH_LEN;
			byte_pos_d  = '0;
			decl_len_d  = '0;
			ver_nz_d    = 1'b0;
			id_match_d  = 1'b1;
			field_d     = '0;
			fcount_d    = '0;
			keys_left_d = '0;
			key_seen_d  = '0;
			key_pos_d   = '0;
			pay_left_d  = '0;
			pay_pos_d   = '0;
			outcome_d   = STATUS_OK;
		end
	end

	// Parse state advances on every box transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEN;
			byte_pos_q  <= '0;
			decl_len_q  <= '0;
			ver_nz_q    <= 1'b0;
			id_match_q  <= 1'b1;
			field_q     <= '0;
			fcount_q    <= '0;
			keys_left_q <= '0;
			key_seen_q  <= '0;
			key_pos_q   <= '0;
			pay_left_q  <= '0;
			pay_pos_q   <= '0;
			outcome_q   <= STATUS_OK;
		end else if (take) begin
			phase_q     <= phase_d;
			byte_pos_q  <= byte_pos_d;
			decl_len_q  <= decl_len_d;
			ver_nz_q    <= ver_nz_d;
			id_match_q  <= id_match_d;
			field_q     <= field_d;
			fcount_q    <= fcount_d;
			keys_left_q <= keys_left_d;
			key_seen_q  <= key_seen_d;
			key_pos_q   <= key_pos_d;
			pay_left_q  <= pay_left_d;
			pay_pos_q   <= pay_pos_d;
			outcome_q   <= outcome_d;
		end
	end

	// Result register: loaded on a box transfer, emptied on a result transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_d;
		end
	end

	// System-id registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sysid_high_q <= '0;
			sysid_low_q  <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SYSID_HIGH: sysid_high_q <= cfg.data;
				REG_SYSID_LOW:  sysid_low_q  <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	assign result.valid          = res_valid_q;
	assign result.byte_kind      = res_q.byte_kind;
	assign result.out_byte       = res_q.out_byte;
	assign result.key_index      = res_q.key_index;
	assign result.key_byte_pos   = res_q.key_byte_pos;
	assign result.payload_offset = res_q.payload_offset;
	assign result.done_res       = res_q.done_res;
	assign result.status         = res_q.status;

endmodule

`default_nettype wire

/* sv/pssh_checker.sv */
//------------------------------------------------------------------------------
// Protection-system box parser checker
// Port-level assertions on the result channel, bound to the parser.
//------------------------------------------------------------------------------
`default_nettype none

module pssh_checker
	import pssh_pkg::*;
(
	input wire                 clk,
	input wire                 arst_n,
	input wire                 in_valid,
	input wire                 in_ready,
	input wire                 out_valid,
	input wire                 out_ready,
	input wire [1:0]           byte_kind,
	input wire [7:0]           out_byte,
	input wire [KEY_IDX_W-1:0] key_index,
	input wire [KEY_POS_W-1:0] key_byte_pos,
	input wire [WORD_W-1:0]    payload_offset,
	input wire                 done_res,
	input wire [1:0]           status
);

	// A held result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	// A box byte taken always yields a result in the next cycle.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("box transfer gave no result");

	// Only the last byte of a box carries a status.
	a_status_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> status == STATUS_OK)
		else $error("status outside the last byte");

	// A result that emits nothing carries no byte or position.
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_kind == KIND_NONE |->
			out_byte == 8'd0 && key_index == '0 && key_byte_pos == '0 &&
			payload_offset == '0)
		else $error("empty result carries data");

	// Key positions belong to key-id bytes only.
	a_kind_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_kind == KIND_PAYLOAD |->
			key_index == '0 && key_byte_pos == '0)
		else $error("payload byte carries a key position");

endmodule

bind pssh_box_parser pssh_checker u_pssh_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (box.valid),
	.in_ready       (box.ready),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.byte_kind      (result.byte_kind),
	.out_byte       (result.out_byte),
	.key_index      (result.key_index),
	.key_byte_pos   (result.key_byte_pos),
	.payload_offset (result.payload_offset),
	.done_res       (result.done_res),
	.status         (result.status)
);

`default_nettype wire

/* test/pssh_box_parser_tb.sv */
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// Protection-system box parser testbench
// Feeds box bytes through the parser under random back-pressure and compares
// every result transfer with a cycle-free model of the parse, across several
// accepted system ids.
//------------------------------------------------------------------------------

module pssh_box_parser_tb
	import pssh_pkg::*;
;

	localparam int CLK_PERIOD  = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_AT     = 1200;
	localparam int REPORT_MAX  = 10;

	// Progress of the model through one box.
	typedef enum logic [3:0] {
		AT_LENGTH, AT_TYPE, AT_VERSION, AT_FLAGS, AT_SYSTEM_ID, AT_KEY_COUNT,
		AT_KEY_IDS, AT_DATA_SIZE, AT_PAYLOAD, AT_END, AT_SKIP
	} box_phase_t;

	// Shapes of box that the random part builds.
	typedef enum int {
		BOX_GOOD, BOX_OTHER_SYSTEM, BOX_LENGTH_MISMATCH, BOX_TOO_MANY_KEYS,
		BOX_BIG_PAYLOAD, BOX_TRUNCATED, BOX_NO_LAST, BOX_SIZE_CHANGE, BOX_NOISE,
		BOX_KIND_COUNT
	} box_kind_t;

	typedef struct packed {
		logic [7:0]        data;
		logic [WORD_W-1:0] size;
		logic              last;
	} box_byte_t;

	typedef struct {
		box_byte_t stim;
		bit        fixed;
		result_t   want;
	} directed_row_t;

	localparam result_t QUIET = '0;

	logic clk = 1'b0;
	logic arst_n;

	pssh_in_if  box_ch ();
	pssh_out_if res_ch ();
	pssh_cfg_if cfg_ch ();

	pssh_box_parser uut (
		.clk    (clk),
		.arst_n (arst_n),
		.box    (box_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	//--------------------------------------------------------------------------
	// Model of the parser. It keeps its own copy of the accepted system id and
	// of the parse state, and is stepped once for every accepted box byte.
	//--------------------------------------------------------------------------
	logic [63:0]          id_high, id_low;
	box_phase_t           box_phase;
	logic [31:0]          pos_count;
	logic [31:0]          declared_len;
	logic                 has_key_list;
	logic                 id_ok;
	logic [31:0]          word_acc;
	logic [31:0]          keys_to_go;
	logic [KEY_IDX_W-1:0] keys_done;
	logic [KEY_POS_W-1:0] key_pos;
	logic [31:0]          payload_to_go;
	logic [31:0]          payload_at;
	logic [1:0]           box_outcome;
	int unsigned          field_idx;

	// Expected results, oldest first.
	result_t parser_outputs_due [$];

	// Bytes of boxes that have been built but not yet sent.
	box_byte_t pending_bytes [$];

	int items_sent, results_seen, mismatches, boxes_built, id_settings;
	int key_bytes_seen, payload_bytes_seen;
	int status_seen [4];
	bit held_off;

	function automatic void restart_box();
		box_phase     = AT_LENGTH;
		pos_count     = '0;
		declared_len  = '0;
		has_key_list  = 1'b0;
		id_ok         = 1'b1;
		word_acc      = '0;
		keys_to_go    = '0;
		keys_done     = '0;
		key_pos       = '0;
		payload_to_go = '0;
		payload_at    = '0;
		box_outcome   = STATUS_OK;
		field_idx     = 0;
	endfunction

	function automatic logic [31:0] bytes_left();
		return (declared_len > pos_count) ? declared_len - pos_count : '0;
	endfunction

	// Shifts one big-endian byte into the word; true once four have arrived.
	function automatic bit word_done(input logic [7:0] b);
		word_acc = {word_acc[23:0], b};
		field_idx++;
		if (field_idx >= 4) begin
			field_idx = 0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic [7:0] wanted_id_byte(input logic [3:0] k);
		logic [SYSID_BITS-1:0] whole;
		whole = {id_high, id_low};
		return whole[SYSID_BITS - 1 - 8 * k -: 8];
	endfunction

	function automatic result_t closing(input logic [1:0] st);
		result_t r;
		r = QUIET;
		r.done_res = 1'b1;
		r.status = st;
		return r;
	endfunction

	function automatic result_t parse_box_byte(input box_byte_t it);
		result_t    r;
		logic [35:0] key_bytes_needed;
		r = QUIET;
		pos_count = pos_count + 1;
		case (box_phase)
			AT_LENGTH: begin
				if (word_done(it.data)) begin
					declared_len = word_acc;
					word_acc = '0;
					if (declared_len != it.size) begin
						box_outcome = STATUS_MISMATCH;
						box_phase = AT_SKIP;
					end else begin
						box_phase = AT_TYPE;
					end
				end
			end
			AT_TYPE: begin
				field_idx++;
				if (field_idx >= 4) begin
					field_idx = 0;
					box_phase = AT_VERSION;
				end
			end
			AT_VERSION: begin
				has_key_list = (it.data != 8'd0);
				box_phase = AT_FLAGS;
			end
			AT_FLAGS: begin
				field_idx++;
				if (field_idx >= 3) begin
					field_idx = 0;
					box_phase = AT_SYSTEM_ID;
				end
			end
			AT_SYSTEM_ID: begin
				if (it.data != wanted_id_byte(field_idx[3:0]))
					id_ok = 1'b0;
				field_idx++;
				if (field_idx >= SYSTEM_ID_BYTES) begin
					field_idx = 0;
					word_acc = '0;
					if (!id_ok) begin
						box_outcome = STATUS_SKIPPED;
						box_phase = AT_SKIP;
					end else begin
						box_phase = has_key_list ? AT_KEY_COUNT : AT_DATA_SIZE;
					end
				end
			end
			AT_KEY_COUNT: begin
				if (word_done(it.data)) begin
					// The count times sixteen must fit in what is left of the box.
					key_bytes_needed = {word_acc, 4'b0000};
					if (key_bytes_needed > {4'b0000, bytes_left()}) begin
						box_outcome = STATUS_INVALID;
						box_phase = AT_SKIP;
					end else begin
						keys_to_go = word_acc;
						keys_done = '0;
						key_pos = '0;
						box_phase = (keys_to_go != 0) ? AT_KEY_IDS : AT_DATA_SIZE;
					end
					word_acc = '0;
				end
			end
			AT_KEY_IDS: begin
				r.byte_kind = KIND_KEY;
				r.out_byte = it.data;
				r.key_index = keys_done;
				r.key_byte_pos = key_pos;
				if (key_pos == KEY_POS_W'(KEY_ID_BYTES - 1)) begin
					key_pos = '0;
					keys_done = keys_done + KEY_IDX_W'(1);
					keys_to_go = keys_to_go - 32'd1;
					if (keys_to_go == 0)
						box_phase = AT_DATA_SIZE;
				end else begin
					key_pos = key_pos + KEY_POS_W'(1);
				end
			end
			AT_DATA_SIZE: begin
				if (word_done(it.data)) begin
					payload_to_go = word_acc;
					payload_at = '0;
					word_acc = '0;
					if (payload_to_go > bytes_left()) begin
						box_outcome = STATUS_INVALID;
						box_phase = AT_SKIP;
					end else begin
						box_phase = (payload_to_go != 0) ? AT_PAYLOAD : AT_END;
					end
				end
			end
			AT_PAYLOAD: begin
				r.byte_kind = KIND_PAYLOAD;
				r.out_byte = it.data;
				r.payload_offset = payload_at;
				payload_at = payload_at + 32'd1;
				payload_to_go = payload_to_go - 32'd1;
				if (payload_to_go == 0)
					box_phase = AT_END;
			end
			default: ;
		endcase
		if (it.last) begin
			// A box that stopped short of its payload end is invalid unless an
			// earlier error has already decided its status.
			r.done_res = 1'b1;
			if (box_outcome != STATUS_OK)
				r.status = box_outcome;
			else
				r.status = (box_phase == AT_END) ? STATUS_OK : STATUS_INVALID;
			restart_box();
		end
		return r;
	endfunction

	//--------------------------------------------------------------------------
	// Box builder. Each call appends one box, or a burst of noise, to the
	// queue of bytes waiting to be sent.
	//--------------------------------------------------------------------------
	task automatic push_word(ref logic [7:0] q [$], input logic [31:0] w);
		for (int s = 24; s >= 0; s -= 8)
			q.push_back(w[s +: 8]);
	endtask

	function automatic box_kind_t next_box_kind();
		int pick;
		box_kind_t kind;
		// The first few boxes walk through every shape once in order.
		if (boxes_built < BOX_KIND_COUNT) begin
			kind = box_kind_t'(boxes_built);
		end else begin
			pick = $urandom_range(99);
			if (pick < 50)      kind = BOX_GOOD;
			else if (pick < 58) kind = BOX_OTHER_SYSTEM;
			else if (pick < 64) kind = BOX_LENGTH_MISMATCH;
			else if (pick < 70) kind = BOX_TOO_MANY_KEYS;
			else if (pick < 76) kind = BOX_BIG_PAYLOAD;
			else if (pick < 84) kind = BOX_TRUNCATED;
			else if (pick < 88) kind = BOX_NO_LAST;
			else if (pick < 93) kind = BOX_SIZE_CHANGE;
			else                kind = BOX_NOISE;
		end
		boxes_built++;
		return kind;
	endfunction

	task automatic queue_box(input box_kind_t kind);
		logic [7:0]  body [$];
		logic [7:0]  ver;
		logic [7:0]  id_b;
		logic [31:0] total, length_field, size_word, key_count, payload_len;
		int          n_keys, n_payload, n_tail, keep, flip_at;
		box_byte_t   it;

		if (kind == BOX_NOISE) begin
			repeat ($urandom_range(1, 20)) begin
				it.data = 8'($urandom);
				it.size = $urandom;
				it.last = ($urandom_range(9) == 0);
				pending_bytes.push_back(it);
			end
			return;
		end

		n_keys = $urandom_range(0, 3);
		n_payload = $urandom_range(0, 12);
		n_tail = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
		ver = (kind == BOX_TOO_MANY_KEYS || $urandom_range(1)) ? 8'($urandom_range(1, 255)) : 8'd0;
		if (ver == 0)
			n_keys = 0;
		total = 28 + ((ver != 0) ? 4 + KEY_ID_BYTES * n_keys : 0) + 4 + n_payload + n_tail;

		length_field = total;
		size_word = total;
		if (kind == BOX_LENGTH_MISMATCH) begin
			length_field = ($urandom_range(1)) ? $urandom : total;
			size_word = $urandom;
			if (size_word == length_field)
				size_word = size_word ^ 32'd1;
		end

		push_word(body, length_field);
		repeat (4) body.push_back(8'($urandom));
		body.push_back(ver);
		repeat (3) body.push_back(8'($urandom));
		flip_at = (kind == BOX_OTHER_SYSTEM) ? $urandom_range(SYSTEM_ID_BYTES - 1) : -1;
		for (int k = 0; k < SYSTEM_ID_BYTES; k++) begin
			id_b = wanted_id_byte(4'(k));
			if (k == flip_at)
				id_b = id_b ^ 8'($urandom_range(1, 255));
			body.push_back(id_b);
		end

		if (ver != 0) begin
			key_count = n_keys;
			if (kind == BOX_TOO_MANY_KEYS) begin
				// Anything above what the rest of the box can hold.
				key_count = $urandom;
				if (key_count <= (total - 32) / KEY_ID_BYTES)
					key_count = (total - 32) / KEY_ID_BYTES + 1 + $urandom_range(0, 3);
			end
			push_word(body, key_count);
			repeat (KEY_ID_BYTES * n_keys) body.push_back(8'($urandom));
		end

		payload_len = n_payload;
		if (kind == BOX_BIG_PAYLOAD) begin
			payload_len = $urandom;
			if (payload_len <= n_payload + n_tail)
				payload_len = n_payload + n_tail + 1 + $urandom_range(0, 3);
		end
		push_word(body, payload_len);
		repeat (n_payload + n_tail) body.push_back(8'($urandom));

		// Cut the box somewhere before its payload has ended.
		if (kind == BOX_TRUNCATED) begin
			keep = $urandom_range(1, total - n_tail - 1);
			while (body.size() > keep)
				void'(body.pop_back());
		end

		for (int i = 0; i < body.size(); i++) begin
			it.data = body[i];
			// Only the size seen with the fourth length byte matters.
			it.size = (kind == BOX_SIZE_CHANGE && i != 3) ? $urandom : size_word;
			it.last = (kind != BOX_NO_LAST) && (i == body.size() - 1);
			pending_bytes.push_back(it);
		end
	endtask

	//--------------------------------------------------------------------------
	// Box channel driver. Idles now and then, except in a stretch in the
	// middle of the run, and steps the model on every accepted transfer.
	//--------------------------------------------------------------------------
	task automatic offer(input box_byte_t it, input bit fixed, input result_t want);
		result_t predicted;
		while (!(items_sent inside {[700:999]}) && $urandom_range(99) < 8) begin
			box_ch.valid <= 1'b0;
			@(posedge clk);
		end
		box_ch.valid <= 1'b1;
		box_ch.data_byte <= it.data;
		box_ch.buffer_size <= it.size;
		box_ch.last_byte <= it.last;
		@(posedge clk);
		while (!box_ch.ready)
			@(posedge clk);
		items_sent++;
		predicted = parse_box_byte(it);
		// A row of the directed table may carry its own expected result.
		parser_outputs_due.push_back(fixed ? want : predicted);
	endtask

	task automatic run_boxes(input int count);
		int sent;
		sent = 0;
		// Always finish the box in hand, so that a phase ends between boxes.
		while (sent < count || pending_bytes.size() != 0) begin
			if (pending_bytes.size() == 0)
				queue_box(next_box_kind());
			offer(pending_bytes.pop_front(), 1'b0, QUIET);
			sent++;
		end
	endtask

	// Both halves of the id go out back to back, with valid held high between.
	task automatic load_system_id(input logic [63:0] hi, input logic [63:0] lo);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= REG_SYSID_HIGH;
		cfg_ch.data <= hi;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		id_high = hi;
		cfg_ch.index <= REG_SYSID_LOW;
		cfg_ch.data <= lo;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		id_low = lo;
		cfg_ch.valid <= 1'b0;
		id_settings++;
	endtask

	// Waits until every expected result has been taken, then a few cycles more.
	task automatic wait_for_results(input int settle);
		while (parser_outputs_due.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	//--------------------------------------------------------------------------
	// Result checking.
	//--------------------------------------------------------------------------
	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] seen);
		if (want !== seen) begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("result %0d: %s expected 0x%0h, got 0x%0h",
					results_seen, name, want, seen);
		end
	endtask

	task automatic check_result();
		result_t got, want;
		got.byte_kind      = res_ch.byte_kind;
		got.out_byte       = res_ch.out_byte;
		got.key_index      = res_ch.key_index;
		got.key_byte_pos   = res_ch.key_byte_pos;
		got.payload_offset = res_ch.payload_offset;
		got.done_res       = res_ch.done_res;
		got.status         = res_ch.status;
		results_seen++;
		if (parser_outputs_due.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("result %0d arrived with nothing expected: 0x%0h",
					results_seen, got);
			return;
		end
		want = parser_outputs_due.pop_front();
		compare_field("byte_kind", want.byte_kind, got.byte_kind);
		compare_field("out_byte", want.out_byte, got.out_byte);
		compare_field("key_index", want.key_index, got.key_index);
		compare_field("key_byte_pos", want.key_byte_pos, got.key_byte_pos);
		compare_field("payload_offset", want.payload_offset, got.payload_offset);
		compare_field("done_res", want.done_res, got.done_res);
		compare_field("status", want.status, got.status);
		if (got.byte_kind == KIND_KEY)
			key_bytes_seen++;
		if (got.byte_kind == KIND_PAYLOAD)
			payload_bytes_seen++;
		if (got.done_res === 1'b1)
			status_seen[got.status]++;
	endtask

	// Result receiver. Stalls now and then, and once holds ready low for a
	// long stretch so that the result register fills and the box input stalls.
	initial begin
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (results_seen == HOLD_AT && !held_off) begin
				held_off = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			res_ch.ready <= (results_seen inside {[700:999]}) || ($urandom_range(99) >= 8);
			@(posedge clk);
			if (res_ch.valid && res_ch.ready)
				check_result();
		end
	end

	//--------------------------------------------------------------------------
	// Main sequence.
	//--------------------------------------------------------------------------
	directed_row_t directed_rows [24];

	initial begin
		box_ch.valid = 1'b0;
		box_ch.data_byte = '0;
		box_ch.buffer_size = '0;
		box_ch.last_byte = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_SYSID_HIGH;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		id_high = '0;
		id_low = '0;
		restart_box();
		id_settings = 1;

		// Short boxes that end in the header. The results of most rows follow
		// directly from the bytes; the last box, whose buffer size wanders on
		// every byte but the fourth, is left to the model.
		directed_rows = '{
			// A lone last byte straight after reset.
			'{'{8'h00, 32'h0000_0000, 1'b1}, 1'b1, closing(STATUS_INVALID)},
			// Largest length, matching the largest buffer size, then cut short.
			'{'{8'hFF, 32'hFFFF_FFFF, 1'b0}, 1'b1, QUIET},
			'{'{8'hFF, 32'hFFFF_FFFF, 1'b0}, 1'b1, QUIET},
			'{'{8'hFF, 32'hFFFF_FFFF, 1'b0}, 1'b1, QUIET},
			'{'{8'hFF, 32'hFFFF_FFFF, 1'b0}, 1'b1, QUIET},
			'{'{8'h00, 32'h0000_0000, 1'b1}, 1'b1, closing(STATUS_INVALID)},
			// Length of five against a buffer size of zero.
			'{'{8'h00, 32'h0000_0000, 1'b0}, 1'b1, QUIET},
			'{'{8'h00, 32'h0000_0000, 1'b0}, 1'b1, QUIET},
			'{'{8'h00, 32'h0000_0000, 1'b0}, 1'b1, QUIET},
			'{'{8'h05, 32'h0000_0000, 1'b0}, 1'b1, QUIET},
			'{'{8'hAA, 32'h0000_0000, 1'b1}, 1'b1, closing(STATUS_MISMATCH)},
			// Zero length and zero size agree, then the box stops in its type.
			'{'{8'h00, 32'h0000_0000, 1'b0}, 1'b1, QUIET},
			'{'{8'h00, 32'h0000_0000, 1'b0}, 1'b1, QUIET},
			'{'{8'h00, 32'h0000_0000, 1'b0}, 1'b1, QUIET},
			'{'{8'h00, 32'h0000_0000, 1'b0}, 1'b1, QUIET},
			'{'{8'hFF, 32'h0000_0000, 1'b1}, 1'b1, closing(STATUS_INVALID)},
			// Mismatch found on the very byte that carries the last mark.
			'{'{8'h00, 32'h0000_0009, 1'b0}, 1'b1, QUIET},
			'{'{8'h00, 32'h0000_0009, 1'b0}, 1'b1, QUIET},
			'{'{8'h00, 32'h0000_0009, 1'b0}, 1'b1, QUIET},
			'{'{8'h07, 32'h0000_0009, 1'b1}, 1'b1, closing(STATUS_MISMATCH)},
			// Buffer size changing while the length is read.
			'{'{8'h00, 32'h1234_5678, 1'b0}, 1'b0, QUIET},
			'{'{8'h00, 32'h0000_0000, 1'b0}, 1'b0, QUIET},
			'{'{8'h00, 32'hFFFF_FFFF, 1'b0}, 1'b0, QUIET},
			'{'{8'h09, 32'h0000_0009, 1'b1}, 1'b0, QUIET}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The first phase runs with the all-zero id left by reset.
		foreach (directed_rows[i])
			offer(directed_rows[i].stim, directed_rows[i].fixed, directed_rows[i].want);
		run_boxes(260);

		for (int setting = 1; setting <= 4; setting++) begin
			box_ch.valid <= 1'b0;
			// Every byte gives a result in the cycle after it is taken, so once
			// the queue is empty the parser is idle.
			wait_for_results(2);
			case (setting)
				1: load_system_id('1, '1);
				2: load_system_id({$urandom, $urandom}, {$urandom, $urandom});
				3: load_system_id('0, '1);
				default: load_system_id({$urandom, $urandom}, '0);
			endcase
			run_boxes((setting == 2) ? 320 : 270);
		end
		box_ch.valid <= 1'b0;
		wait_for_results(8);

		$display("Checked %0d box bytes over %0d system-id settings: %0d key-id and %0d payload bytes.",
			items_sent, id_settings, key_bytes_seen, payload_bytes_seen);
		$display("Box endings: %0d processed, %0d other system, %0d length mismatch, %0d invalid.",
			status_seen[STATUS_OK], status_seen[STATUS_SKIPPED],
			status_seen[STATUS_MISMATCH], status_seen[STATUS_INVALID]);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog well beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
